// ===== src/sde_pkg.sv =====
package sde_pkg;

    // the variance quotient carries this many fraction bits (sd carries half)
    localparam int FRAC_SHIFT = 16;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_P  = 8'b0000_0010,
        ST_MUL_Q  = 8'b0000_0100,
        ST_SUB    = 8'b0000_1000,
        ST_MUL_D  = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_SQRT   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic accum;      // take the sample on the input ports
        logic mul_p;      // shift-add step of n * sum of squares
        logic mul_q;      // shift-add step of |sum| * |sum|
        logic mul_d;      // shift-add step of n * n
        logic save_num;   // park n * sum of squares in the divide register
        logic sub;        // numerator minus squared sum, clamped at zero
        logic div_step;   // one restoring divide step
        logic sqrt_step;  // one digit of the square root
        logic finish;     // load the result word and clear the run
    } cmd_t;

endpackage

// ===== src/sde_ctrl.sv =====
module sde_ctrl
    import sde_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 1024,
    localparam int CW  = $clog2(MAX_SAMPLES + 1),
    localparam int S1W = SAMPLE_BITS + CW - 1,
    localparam int S2W = 2 * SAMPLE_BITS + CW - 1,
    localparam int MW  = S1W,
    localparam int AW  = S2W + CW,
    localparam int DW  = AW + FRAC_SHIFT,
    localparam int RW  = SAMPLE_BITS + 8,
    localparam int CTW = $clog2(DW)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last,
    output logic           busy,
    output cmd_t           cmd,
    output logic [CTW-1:0] step_idx
);

    localparam logic [CTW-1:0] MUL_LAST  = CTW'(MW - 1);
    localparam logic [CTW-1:0] DIV_LAST  = CTW'(DW - 1);
    localparam logic [CTW-1:0] SQRT_LAST = CTW'(RW - 1);

    state_t         state_reg;
    state_t         state_next;
    logic [CTW-1:0] ctr_reg;
    logic [CTW-1:0] ctr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctr_next   = ctr_reg + CTW'(1);
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctr_next  = '0;
                cmd.accum = start;
                if (start && last)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                cmd.mul_p = 1'b1;
                if (ctr_reg == MUL_LAST)
                begin
                    cmd.save_num = 1'b1;
                    ctr_next     = '0;
                    state_next   = ST_MUL_Q;
                end
            end
            ST_MUL_Q:
            begin
                cmd.mul_q = 1'b1;
                if (ctr_reg == MUL_LAST)
                begin
                    ctr_next   = '0;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                ctr_next   = '0;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_d = 1'b1;
                if (ctr_reg == MUL_LAST)
                begin
                    ctr_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (ctr_reg == DIV_LAST)
                begin
                    ctr_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (ctr_reg == SQRT_LAST)
                begin
                    ctr_next   = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                ctr_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                ctr_next   = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign step_idx = ctr_reg;

endmodule

// ===== src/sde_datapath.sv =====
module sde_datapath
    import sde_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 1024,
    localparam int SB   = SAMPLE_BITS,
    localparam int CW   = $clog2(MAX_SAMPLES + 1),
    localparam int S1W  = SB + CW - 1,
    localparam int S2W  = 2 * SB + CW - 1,
    localparam int MW   = S1W,
    localparam int AW   = S2W + CW,
    localparam int DW   = AW + FRAC_SHIFT,
    localparam int RW   = SB + 8,
    localparam int DENW = 2 * CW,
    localparam int CTW  = $clog2(DW),
    localparam int IDXW = $clog2(MW)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  cmd_t           cmd,
    input  logic [CTW-1:0] step_idx,
    input  logic [SB-1:0]  sample,
    output logic           done,
    output logic [RW-1:0]  std_dev,
    output logic [CW-1:0]  sample_count,
    output logic           overflowed
);

    // running state of the current run
    logic signed [S1W-1:0] sum_reg;
    logic [S2W-1:0]        sq_sum_reg;
    logic [CW-1:0]         count_reg;
    logic                  dropped_reg;

    // back end working registers
    logic [AW-1:0]   acc_reg;
    logic [DW-1:0]   dq_reg;
    logic [DENW-1:0] rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW+1:0]   srem_reg;

    // result word
    logic [RW-1:0] std_dev_reg;
    logic [CW-1:0] count_out_reg;
    logic          ovf_reg;
    logic          done_reg;

    logic signed [SB-1:0]   sample_s;
    logic signed [2*SB-1:0] sample_sq;
    logic signed [S1W-1:0]  sample_ext;
    logic [S2W-1:0]         sq_ext;
    logic                   room;
    logic [S1W-1:0]         sum_abs;
    logic [AW-1:0]          mcand;
    logic [MW-1:0]          mplier;
    logic                   mul_bit;
    logic [AW-1:0]          acc_step;
    logic [AW-1:0]          num_hi;
    logic                   num_ge;
    logic [AW-1:0]          num_diff;
    logic [DENW:0]          div_shift;
    logic [DENW:0]          div_den;
    logic                   div_ge;
    logic [DENW:0]          div_sub;
    logic [RW+3:0]          sqrt_t;
    logic [RW+3:0]          sqrt_trial;
    logic                   sqrt_ge;
    logic [RW+3:0]          sqrt_sub;

    // accumulation front end
    assign sample_s   = sample;
    assign sample_sq  = sample_s * sample_s;
    assign sample_ext = {{(S1W - SB){sample[SB-1]}}, sample};
    assign sq_ext     = {{(S2W - 2 * SB){1'b0}}, sample_sq};
    assign room       = (count_reg < CW'(MAX_SAMPLES));

    assign sum_abs = sum_reg[S1W-1] ? (~sum_reg + S1W'(1)) : sum_reg;

    // shared shift-add multiplier, multiplier bits taken msb first
    always_comb
    begin
        priority if (cmd.mul_p)
        begin
            mcand = {{CW{1'b0}}, sq_sum_reg};
        end
        else if (cmd.mul_q)
        begin
            mcand = {{(AW - S1W){1'b0}}, sum_abs};
        end
        else
        begin
            mcand = {{(AW - CW){1'b0}}, count_reg};
        end
    end

    assign mplier   = cmd.mul_q ? sum_abs : {{(MW - CW){1'b0}}, count_reg};
    assign mul_bit  = mplier[IDXW'(MW - 1) - step_idx[IDXW-1:0]];
    assign acc_step = {acc_reg[AW-2:0], 1'b0} + (mul_bit ? mcand : '0);

    // n*S2 - S1^2, clamped at zero
    assign num_hi   = dq_reg[DW-1:FRAC_SHIFT];
    assign num_ge   = (num_hi >= acc_reg);
    assign num_diff = num_hi - acc_reg;

    // restoring divide by n*n, quotient bits shift in at the bottom
    assign div_shift = {rem_reg, dq_reg[DW-1]};
    assign div_den   = {1'b0, acc_reg[DENW-1:0]};
    assign div_ge    = (div_shift >= div_den);
    assign div_sub   = div_shift - div_den;

    // digit-by-digit square root over the low quotient bits
    assign sqrt_t     = {srem_reg, dq_reg[2*RW-1 -: 2]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};
    assign sqrt_ge    = (sqrt_t >= sqrt_trial);
    assign sqrt_sub   = sqrt_t - sqrt_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            sq_sum_reg  <= '0;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                sum_reg     <= '0;
                sq_sum_reg  <= '0;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
            else if (cmd.accum)
            begin
                if (room)
                begin
                    sum_reg    <= sum_reg + sample_ext;
                    sq_sum_reg <= sq_sum_reg + sq_ext;
                    count_reg  <= count_reg + CW'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accum || cmd.save_num || cmd.sub)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mul_p || cmd.mul_q || cmd.mul_d)
        begin
            acc_reg <= acc_step;
        end

        if (cmd.save_num)
        begin
            dq_reg <= {acc_step, {FRAC_SHIFT{1'b0}}};
        end
        else if (cmd.sub)
        begin
            dq_reg <= {(num_ge ? num_diff : {AW{1'b0}}), {FRAC_SHIFT{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[DW-2:0], div_ge};
        end
        else if (cmd.sqrt_step)
        begin
            dq_reg <= {dq_reg[DW-3:0], 2'b00};
        end

        if (cmd.sub)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_sub[DENW-1:0] : div_shift[DENW-1:0];
        end
        else if (cmd.sqrt_step)
        begin
            root_reg <= {root_reg[RW-2:0], sqrt_ge};
            srem_reg <= sqrt_ge ? sqrt_sub[RW+1:0] : sqrt_t[RW+1:0];
        end

        if (cmd.finish)
        begin
            std_dev_reg   <= (count_reg == '0) ? '0 : root_reg;
            count_out_reg <= count_reg;
            ovf_reg       <= dropped_reg;
        end
    end

    assign done         = done_reg;
    assign std_dev      = std_dev_reg;
    assign sample_count = count_out_reg;
    assign overflowed   = ovf_reg;

endmodule

// ===== src/standard_deviation_engine_unit.sv =====
// channel   direction  handshake             word
// -------   ---------  --------------------  ---------------------------------------
// sample    in         start & !busy         sample, last
// result    out        done (one-cycle)      std_dev, sample_count, overflowed
//
// samples are taken one per cycle while busy is low; the word with last set
// closes the run and raises busy while the back end forms n*S2 and S1^2 on the
// shared shift-add multiplier, subtracts them with a clamp at zero, forms n*n,
// then runs the bit-serial divider and the bit-serial square root and loads the
// result word
// done pulses in the first cycle with busy low; a new run may start in that cycle
// rst_n clears the sequencer and the running sums; there is no stall on the
// result side, so done marks each result word for exactly one cycle
module standard_deviation_engine_unit
    import sde_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  logic                               last,
    output logic                               done,
    output logic [SAMPLE_BITS+7:0]             std_dev,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]   sample_count,
    output logic                               overflowed
);

    // widths of the back end, kept in step with the two submodules
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = 2 * SAMPLE_BITS + 2 * CW - 1;
    localparam int DW  = AW + FRAC_SHIFT;
    localparam int CTW = $clog2(DW);

    cmd_t           cmd;
    logic [CTW-1:0] step_idx;

    // sequencer: accepts words while idle, then walks the back end phases
    sde_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last     (last),
        .busy     (busy),
        .cmd      (cmd),
        .step_idx (step_idx)
    );

    // datapath: running sums, shared multiplier, divider, root and result word
    sde_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .step_idx     (step_idx),
        .sample       (sample),
        .done         (done),
        .std_dev      (std_dev),
        .sample_count (sample_count),
        .overflowed   (overflowed)
    );

endmodule
